/* rtl/core/slcp_pkg.sv */
// slcp_pkg: widths, item types and constants shared by the closest-points core.
// No dependencies; every file of the core imports it.

package slcp_pkg;

  // coordinate format
  localparam int CW = 32;
  localparam int FB = 16;

  // lanes: 0..2 first line x/y/z, 3..5 second line x/y/z
  localparam int NL = 6;
  localparam int NAXIS = 3;

  // gram terms a..e and their split for the wide products
  localparam int GW = 2 * CW + 4;
  localparam int HG = GW / 2;
  localparam int PPW = GW + 2;
  localparam int PW = 2 * GW;
  localparam int NPROD = 6;

  // determinant and numerators
  localparam int DW = PW + 1;
  localparam int NLIMB = (DW + CW - 1) / CW;
  localparam int NPW = 2 * CW + 1;
  localparam int NW = (NLIMB + 1) * CW;

  // divider
  localparam int QB = CW + 1;
  localparam int RW = DW + QB;
  localparam int HW = NW + QB;
  localparam int VW = CW + 3;

  // squared gap
  localparam int SQW = 2 * CW + 2;
  localparam int GSW = 2 * CW + 4;
  localparam int GAPW = 64;
  localparam int GXW = (GSW > GAPW) ? GSW : GAPW + 1;
  localparam logic [GSW-1:0] GAP_RND = (FB > 0) ? (GSW'(1) << ((FB > 0) ? FB - 1 : 0)) : '0;

  // queue between front and back
  localparam int QD = 4;
  localparam int QPW = $clog2(QD);

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [GW-1:0] gram_t;

  localparam coord_t COORD_MAX = {1'b0, {(CW - 1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(CW - 1){1'b0}}};

  typedef struct packed {
    gram_t a;
    gram_t b;
    gram_t c;
    gram_t d;
    gram_t e;
    coord_t [NL-1:0] dir;
    coord_t [NL-1:0] base;
  } gram_item_t;

  typedef struct packed {
    logic par;
    logic [NL-1:0] neg;
    logic [NL-1:0] huge;
    coord_t [NL-1:0] base;
  } div_side_t;

  typedef struct packed {
    coord_t [NL-1:0] near;
    logic [GAPW-1:0] gap;
    logic par;
  } result_t;

endpackage

/* rtl/core/skew_line_closest_points_core.sv */
// skew_line_closest_points_core: closest points between two 3D lines, top level.
// Depends on slcp_pkg, slcp_front, slcp_queue, slcp_back.
//
// Each item is two lines (direction and base point, signed Q16.16). The core returns
// the closest point on each line, rounded to nearest (ties away from zero) and
// saturated, the squared gap in unsigned Q48.16 (half-up, saturated), and a flag for
// parallel or degenerate pairs, which return the base points. One item is taken per
// cycle sustained while results are popped; the longest part of the pipeline is the
// 33-stage restoring divider that yields one quotient bit per stage. A 4-entry queue
// sits between the gram-term front end and the solver. While a result waits to be
// popped the whole solver holds, and the input side keeps taking items until the queue
// is full and the last front stage holds one (at most seven items), then raises full.

module skew_line_closest_points_core (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push,
  output logic full,
  input  logic signed [slcp_pkg::CW-1:0] first_dir_x_i,
  input  logic signed [slcp_pkg::CW-1:0] first_dir_y_i,
  input  logic signed [slcp_pkg::CW-1:0] first_dir_z_i,
  input  logic signed [slcp_pkg::CW-1:0] first_base_x_i,
  input  logic signed [slcp_pkg::CW-1:0] first_base_y_i,
  input  logic signed [slcp_pkg::CW-1:0] first_base_z_i,
  input  logic signed [slcp_pkg::CW-1:0] second_dir_x_i,
  input  logic signed [slcp_pkg::CW-1:0] second_dir_y_i,
  input  logic signed [slcp_pkg::CW-1:0] second_dir_z_i,
  input  logic signed [slcp_pkg::CW-1:0] second_base_x_i,
  input  logic signed [slcp_pkg::CW-1:0] second_base_y_i,
  input  logic signed [slcp_pkg::CW-1:0] second_base_z_i,
  output logic empty,
  input  logic pop,
  output logic signed [slcp_pkg::CW-1:0] near_first_x_o,
  output logic signed [slcp_pkg::CW-1:0] near_first_y_o,
  output logic signed [slcp_pkg::CW-1:0] near_first_z_o,
  output logic signed [slcp_pkg::CW-1:0] near_second_x_o,
  output logic signed [slcp_pkg::CW-1:0] near_second_y_o,
  output logic signed [slcp_pkg::CW-1:0] near_second_z_o,
  output logic [slcp_pkg::GAPW-1:0] gap_squared_o,
  output logic lines_parallel_o
);
  import slcp_pkg::*;

  coord_t [NL-1:0] dir, base;
  logic front_ready, fq_valid, fq_ready, qb_valid, qb_ready, out_valid;
  gram_item_t fq_item, qb_item;
  result_t res;

  assign dir[0] = first_dir_x_i;
  assign dir[1] = first_dir_y_i;
  assign dir[2] = first_dir_z_i;
  assign dir[3] = second_dir_x_i;
  assign dir[4] = second_dir_y_i;
  assign dir[5] = second_dir_z_i;
  assign base[0] = first_base_x_i;
  assign base[1] = first_base_y_i;
  assign base[2] = first_base_z_i;
  assign base[3] = second_base_x_i;
  assign base[4] = second_base_y_i;
  assign base[5] = second_base_z_i;

  assign full = !front_ready;

  slcp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (push),
    .ready_o (front_ready),
    .dir_i   (dir),
    .base_i  (base),
    .valid_o (fq_valid),
    .ready_i (fq_ready),
    .item_o  (fq_item)
  );

  slcp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fq_valid),
    .wr_ready_o (fq_ready),
    .wr_item_i  (fq_item),
    .rd_valid_o (qb_valid),
    .rd_ready_i (qb_ready),
    .rd_item_o  (qb_item)
  );

  slcp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (qb_valid),
    .in_ready_o  (qb_ready),
    .in_item_i   (qb_item),
    .out_valid_o (out_valid),
    .out_ready_i (pop),
    .out_res_o   (res)
  );

  assign empty = !out_valid;
  assign near_first_x_o = res.near[0];
  assign near_first_y_o = res.near[1];
  assign near_first_z_o = res.near[2];
  assign near_second_x_o = res.near[3];
  assign near_second_y_o = res.near[4];
  assign near_second_z_o = res.near[5];
  assign gap_squared_o = res.gap;
  assign lines_parallel_o = res.par;

endmodule

/* rtl/core/slcp_front.sv */
// slcp_front: takes line pairs in, forms w = P1 - P2 and the gram terms a..e.
// Depends on slcp_pkg.

module slcp_front (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  slcp_pkg::coord_t [slcp_pkg::NL-1:0] dir_i,
  input  slcp_pkg::coord_t [slcp_pkg::NL-1:0] base_i,
  output logic valid_o,
  input  logic ready_i,
  output slcp_pkg::gram_item_t item_o
);
  import slcp_pkg::*;

  localparam int P2W = 2 * CW + 1;

  logic adv;
  logic f0_v_q, f1_v_q, f2_v_q;
  coord_t [NL-1:0] f0_dir_q, f0_base_q, f1_dir_q, f1_base_q;
  logic signed [CW:0] f0_w_q [NAXIS];
  logic signed [P2W-1:0] f1_aa_q [NAXIS];
  logic signed [P2W-1:0] f1_ab_q [NAXIS];
  logic signed [P2W-1:0] f1_bb_q [NAXIS];
  logic signed [P2W-1:0] f1_aw_q [NAXIS];
  logic signed [P2W-1:0] f1_bw_q [NAXIS];
  gram_item_t f2_q;

  assign adv = !f2_v_q || ready_i;
  assign ready_o = adv;
  assign valid_o = f2_v_q;
  assign item_o = f2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f0_v_q <= 1'b0;
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
    end else if (adv) begin
      f0_v_q <= valid_i;
      f1_v_q <= f0_v_q;
      f2_v_q <= f1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f0_dir_q <= dir_i;
      f0_base_q <= base_i;
      for (int k = 0; k < NAXIS; k++) begin
        f0_w_q[k] <= (CW + 1)'($signed(base_i[k])) - (CW + 1)'($signed(base_i[NAXIS + k]));
      end

      f1_dir_q <= f0_dir_q;
      f1_base_q <= f0_base_q;
      for (int k = 0; k < NAXIS; k++) begin
        f1_aa_q[k] <= $signed(f0_dir_q[k]) * $signed(f0_dir_q[k]);
        f1_ab_q[k] <= $signed(f0_dir_q[k]) * $signed(f0_dir_q[NAXIS + k]);
        f1_bb_q[k] <= $signed(f0_dir_q[NAXIS + k]) * $signed(f0_dir_q[NAXIS + k]);
        f1_aw_q[k] <= $signed(f0_dir_q[k]) * f0_w_q[k];
        f1_bw_q[k] <= $signed(f0_dir_q[NAXIS + k]) * f0_w_q[k];
      end

      f2_q.dir <= f1_dir_q;
      f2_q.base <= f1_base_q;
      f2_q.a <= GW'(f1_aa_q[0]) + GW'(f1_aa_q[1]) + GW'(f1_aa_q[2]);
      f2_q.b <= GW'(f1_ab_q[0]) + GW'(f1_ab_q[1]) + GW'(f1_ab_q[2]);
      f2_q.c <= GW'(f1_bb_q[0]) + GW'(f1_bb_q[1]) + GW'(f1_bb_q[2]);
      f2_q.d <= GW'(f1_aw_q[0]) + GW'(f1_aw_q[1]) + GW'(f1_aw_q[2]);
      f2_q.e <= GW'(f1_bw_q[0]) + GW'(f1_bw_q[1]) + GW'(f1_bw_q[2]);
    end
  end

endmodule

/* rtl/core/slcp_queue.sv */
// slcp_queue: short fifo of gram items between the front and the back.
// Depends on slcp_pkg.

module slcp_queue (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  slcp_pkg::gram_item_t wr_item_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output slcp_pkg::gram_item_t rd_item_o
);
  import slcp_pkg::*;

  gram_item_t mem_q [QD];
  logic [QPW-1:0] wp_q, rp_q;
  logic [QPW:0] cnt_q;
  logic wr, rd;

  assign wr_ready_o = (cnt_q != (QPW + 1)'(QD));
  assign rd_valid_o = (cnt_q != '0);
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_ready_i && rd_valid_o;
  assign rd_item_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + 1'b1;
      if (rd) rp_q <= rp_q + 1'b1;
      if (wr && !rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd && !wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_item_i;
  end

endmodule

/* rtl/core/slcp_div.sv */
// slcp_div: pipelined restoring divider, one quotient bit per stage, six lanes
// sharing one divisor. Depends on slcp_pkg.

module slcp_div (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  logic [slcp_pkg::DW-1:0] det_i,
  input  logic [slcp_pkg::RW-1:0] rem_i [slcp_pkg::NL],
  input  slcp_pkg::div_side_t side_i,
  output logic valid_o,
  output logic [slcp_pkg::DW-1:0] det_o,
  output logic [slcp_pkg::RW-1:0] rem_o [slcp_pkg::NL],
  output logic [slcp_pkg::QB-1:0] quo_o [slcp_pkg::NL],
  output slcp_pkg::div_side_t side_o
);
  import slcp_pkg::*;

  logic v_q [QB];
  logic [DW-1:0] det_q [QB];
  logic [RW-1:0] rem_q [QB][NL];
  logic [QB-1:0] quo_q [QB][NL];
  div_side_t side_q [QB];

  for (genvar s = 0; s < QB; s++) begin : g_stage
    localparam int BIT = QB - 1 - s;
    logic pv;
    logic [DW-1:0] pdet;
    logic [RW-1:0] prem [NL];
    logic [QB-1:0] pquo [NL];
    div_side_t pside;
    logic [RW-1:0] trial;
    logic [NL-1:0] take;

    if (s == 0) begin : g_first
      assign pv = valid_i;
      assign pdet = det_i;
      assign prem = rem_i;
      assign pside = side_i;
      for (genvar l = 0; l < NL; l++) begin : g_lane
        assign pquo[l] = '0;
      end
    end else begin : g_next
      assign pv = v_q[s-1];
      assign pdet = det_q[s-1];
      assign prem = rem_q[s-1];
      assign pquo = quo_q[s-1];
      assign pside = side_q[s-1];
    end

    assign trial = RW'(pdet) << BIT;

    always_comb begin
      for (int l = 0; l < NL; l++) begin
        take[l] = (prem[l] >= trial);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        det_q[s] <= pdet;
        side_q[s] <= pside;
        for (int l = 0; l < NL; l++) begin
          rem_q[s][l] <= take[l] ? prem[l] - trial : prem[l];
          quo_q[s][l] <= pquo[l] | (QB'(take[l]) << BIT);
        end
      end
    end
  end

  assign valid_o = v_q[QB-1];
  assign det_o = det_q[QB-1];
  assign rem_o = rem_q[QB-1];
  assign quo_o = quo_q[QB-1];
  assign side_o = side_q[QB-1];

endmodule

/* rtl/core/slcp_back.sv */
// slcp_back: solves the normal equations, divides, rounds, saturates and forms
// the squared gap. Depends on slcp_pkg and slcp_div.

module slcp_back (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  slcp_pkg::gram_item_t in_item_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output slcp_pkg::result_t out_res_o
);
  import slcp_pkg::*;

  // products formed in the first two stages
  localparam int PR_AC = 0;
  localparam int PR_BB = 1;
  localparam int PR_BE = 2;
  localparam int PR_CD = 3;
  localparam int PR_AE = 4;
  localparam int PR_BD = 5;

  logic en;

  // stage 1 operands and partial products
  gram_t mx [NPROD];
  gram_t my [NPROD];
  logic signed [HG:0] lx [NPROD];
  logic signed [HG:0] ly [NPROD];
  logic signed [GW-HG-1:0] hx [NPROD];
  logic signed [GW-HG-1:0] hy [NPROD];

  logic b1_v_q, b2_v_q, b3_v_q, b4_v_q, b5_v_q, b6_v_q;
  logic signed [PPW-1:0] b1_pp_q [NPROD][4];
  coord_t [NL-1:0] b1_dir_q, b2_dir_q, b3_dir_q;
  coord_t [NL-1:0] b1_base_q, b2_base_q, b3_base_q, b4_base_q, b5_base_q;
  logic signed [PW-1:0] b2_prod_q [NPROD];
  logic signed [DW-1:0] b3_det_q, b4_det_q, b5_det_q;
  logic signed [DW-1:0] b3_n_q [2];
  logic b4_par_q, b5_par_q;

  logic [NLIMB*CW-1:0] nx [2];
  logic signed [CW:0] limb [2][NLIMB];
  logic signed [NPW-1:0] b4_npp_q [NL][NLIMB];
  logic signed [NW-1:0] acc [NL];
  logic signed [NW-1:0] b5_num_q [NL];

  logic [NW-1:0] mag [NL];
  logic [NL-1:0] neg, huge;
  logic [DW-1:0] b6_det_q;
  logic [RW-1:0] b6_rem_q [NL];
  div_side_t b6_side_q;

  logic dv_v;
  logic [DW-1:0] dv_det;
  logic [RW-1:0] dv_rem [NL];
  logic [QB-1:0] dv_quo [NL];
  div_side_t dv_side;

  coord_t [NL-1:0] r_near;
  coord_t [NL-1:0] r_near_q, g1_near_q;
  logic r_v_q, r_par_q, g1_v_q, g1_par_q;
  logic signed [SQW-1:0] g1_sq_q [NAXIS];

  logic [GSW-1:0] gsum;
  logic [GXW-1:0] gsh;
  logic out_v_q;
  result_t out_q;

  assign en = !out_v_q || out_ready_i;
  assign in_ready_o = en;
  assign out_valid_o = out_v_q;
  assign out_res_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q <= 1'b0;
      b2_v_q <= 1'b0;
      b3_v_q <= 1'b0;
      b4_v_q <= 1'b0;
      b5_v_q <= 1'b0;
      b6_v_q <= 1'b0;
      r_v_q <= 1'b0;
      g1_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      b1_v_q <= in_valid_i;
      b2_v_q <= b1_v_q;
      b3_v_q <= b2_v_q;
      b4_v_q <= b3_v_q;
      b5_v_q <= b4_v_q;
      b6_v_q <= b5_v_q;
      r_v_q <= dv_v;
      g1_v_q <= r_v_q;
      out_v_q <= g1_v_q;
    end
  end

  // each operand of a wide product is split into a low unsigned half and a high signed half
  always_comb begin
    mx[PR_AC] = in_item_i.a;
    my[PR_AC] = in_item_i.c;
    mx[PR_BB] = in_item_i.b;
    my[PR_BB] = in_item_i.b;
    mx[PR_BE] = in_item_i.b;
    my[PR_BE] = in_item_i.e;
    mx[PR_CD] = in_item_i.c;
    my[PR_CD] = in_item_i.d;
    mx[PR_AE] = in_item_i.a;
    my[PR_AE] = in_item_i.e;
    mx[PR_BD] = in_item_i.b;
    my[PR_BD] = in_item_i.d;
    for (int j = 0; j < NPROD; j++) begin
      lx[j] = $signed({1'b0, mx[j][HG-1:0]});
      ly[j] = $signed({1'b0, my[j][HG-1:0]});
      hx[j] = $signed(mx[j][GW-1:HG]);
      hy[j] = $signed(my[j][GW-1:HG]);
    end
  end

  // numerators split into limbs for the direction products
  always_comb begin
    for (int g = 0; g < 2; g++) begin
      nx[g] = (NLIMB * CW)'(b3_n_q[g]);
      for (int i = 0; i < NLIMB - 1; i++) begin
        limb[g][i] = $signed({1'b0, nx[g][i*CW +: CW]});
      end
      limb[g][NLIMB-1] = $signed(nx[g][(NLIMB-1)*CW +: CW]);
    end
  end

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      acc[l] = '0;
      for (int i = 0; i < NLIMB; i++) begin
        acc[l] = acc[l] + (NW'(b4_npp_q[l][i]) <<< (i * CW));
      end
    end
  end

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      neg[l] = b5_num_q[l][NW-1];
      mag[l] = neg[l] ? $unsigned(-b5_num_q[l]) : $unsigned(b5_num_q[l]);
      // a quotient this large pushes the point past either rail
      huge[l] = (HW'(mag[l]) >= (HW'($unsigned(b5_det_q)) << QB));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b1_dir_q <= in_item_i.dir;
      b1_base_q <= in_item_i.base;
      for (int j = 0; j < NPROD; j++) begin
        b1_pp_q[j][0] <= lx[j] * ly[j];
        b1_pp_q[j][1] <= hx[j] * ly[j];
        b1_pp_q[j][2] <= lx[j] * hy[j];
        b1_pp_q[j][3] <= hx[j] * hy[j];
      end

      b2_dir_q <= b1_dir_q;
      b2_base_q <= b1_base_q;
      for (int j = 0; j < NPROD; j++) begin
        b2_prod_q[j] <= (PW'(b1_pp_q[j][3]) <<< (2 * HG))
                      + ((PW'(b1_pp_q[j][1]) + PW'(b1_pp_q[j][2])) <<< HG)
                      + PW'(b1_pp_q[j][0]);
      end

      b3_dir_q <= b2_dir_q;
      b3_base_q <= b2_base_q;
      b3_det_q <= DW'(b2_prod_q[PR_AC]) - DW'(b2_prod_q[PR_BB]);
      b3_n_q[0] <= DW'(b2_prod_q[PR_BE]) - DW'(b2_prod_q[PR_CD]);
      b3_n_q[1] <= DW'(b2_prod_q[PR_AE]) - DW'(b2_prod_q[PR_BD]);

      b4_base_q <= b3_base_q;
      b4_det_q <= b3_det_q;
      b4_par_q <= (b3_det_q == '0);
      for (int l = 0; l < NL; l++) begin
        for (int i = 0; i < NLIMB; i++) begin
          b4_npp_q[l][i] <= $signed(b3_dir_q[l]) * limb[l / NAXIS][i];
        end
      end

      b5_base_q <= b4_base_q;
      b5_det_q <= b4_det_q;
      b5_par_q <= b4_par_q;
      for (int l = 0; l < NL; l++) begin
        b5_num_q[l] <= acc[l];
      end

      b6_det_q <= $unsigned(b5_det_q);
      b6_side_q.par <= b5_par_q;
      b6_side_q.neg <= neg;
      b6_side_q.huge <= huge;
      b6_side_q.base <= b5_base_q;
      for (int l = 0; l < NL; l++) begin
        b6_rem_q[l] <= mag[l][RW-1:0];
      end
    end
  end

  slcp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (b6_v_q),
    .det_i   (b6_det_q),
    .rem_i   (b6_rem_q),
    .side_i  (b6_side_q),
    .valid_o (dv_v),
    .det_o   (dv_det),
    .rem_o   (dv_rem),
    .quo_o   (dv_quo),
    .side_o  (dv_side)
  );

  // round half away from zero, add the base point, clamp to the coordinate range; parallel pairs keep the base point
  always_comb begin
    for (int l = 0; l < NL; l++) begin
      logic up;
      logic [QB:0] qr;
      logic signed [VW-1:0] sq, v;
      up = ({dv_rem[l], 1'b0} >= (RW + 1)'(dv_det));
      qr = (QB + 1)'(dv_quo[l]) + (QB + 1)'(up);
      sq = dv_side.neg[l] ? -$signed(VW'(qr)) : $signed(VW'(qr));
      v = VW'($signed(dv_side.base[l])) + sq;
      if (dv_side.par) begin
        r_near[l] = dv_side.base[l];
      end else if (dv_side.huge[l]) begin
        r_near[l] = dv_side.neg[l] ? COORD_MIN : COORD_MAX;
      end else if (v > VW'(COORD_MAX)) begin
        r_near[l] = COORD_MAX;
      end else if (v < VW'(COORD_MIN)) begin
        r_near[l] = COORD_MIN;
      end else begin
        r_near[l] = v[CW-1:0];
      end
    end
  end

  always_comb begin
    gsum = GAP_RND;
    for (int k = 0; k < NAXIS; k++) begin
      gsum = gsum + GSW'($unsigned(g1_sq_q[k]));
    end
    gsh = GXW'(gsum >> FB);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_near_q <= r_near;
      r_par_q <= dv_side.par;

      g1_near_q <= r_near_q;
      g1_par_q <= r_par_q;
      for (int k = 0; k < NAXIS; k++) begin
        g1_sq_q[k] <= ((CW + 1)'(r_near_q[NAXIS + k]) - (CW + 1)'(r_near_q[k]))
                    * ((CW + 1)'(r_near_q[NAXIS + k]) - (CW + 1)'(r_near_q[k]));
      end

      out_q.near <= g1_near_q;
      out_q.par <= g1_par_q;
      out_q.gap <= (gsh > GXW'({GAPW{1'b1}})) ? {GAPW{1'b1}} : gsh[GAPW-1:0];
    end
  end

  a_det_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b3_v_q |-> !b3_det_q[DW-1])
    else $error("determinant came out negative");

  a_rem_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_v && !dv_side.par && !dv_side.huge[0] |-> dv_rem[0] < RW'(dv_det))
    else $error("divider remainder not below determinant, first line");

  a_rem_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_v && !dv_side.par && !dv_side.huge[NAXIS] |-> dv_rem[NAXIS] < RW'(dv_det))
    else $error("divider remainder not below determinant, second line");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(g1_v_q))
    else $error("result appeared without an item in the gap stage");

endmodule

/* verif/tb.sv */
// tb: self-checking testbench for skew_line_closest_points_core.
// Depends on slcp_pkg and the core; computes expected closest points with wide integers.

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import slcp_pkg::*;

  typedef logic signed [CW-1:0] crd_t;
  typedef logic signed [1023:0] wide_t;

  typedef struct {
    crd_t d1[3];
    crd_t p1[3];
    crd_t d2[3];
    crd_t p2[3];
  } pair_t;

  typedef struct {
    crd_t q1[3];
    crd_t q2[3];
    logic [63:0] gap;
    logic par;
  } near_t;

  int errors = 0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic crd_t sat_coord(input wide_t v);
    wide_t hi, lo;
    hi = (wide_t'(1) <<< (CW - 1)) - 1;
    lo = -(wide_t'(1) <<< (CW - 1));
    if (v > hi) return crd_t'(hi);
    if (v < lo) return crd_t'(lo);
    return crd_t'(v);
  endfunction

  // rounded to nearest, ties away from zero
  function automatic wide_t div_round(input wide_t n, input wide_t den);
    wide_t m, q, r;
    m = (n < 0) ? -n : n;
    q = m / den;
    r = m - q * den;
    if (2 * r >= den) q = q + 1;
    return (n < 0) ? -q : q;
  endfunction

  function automatic near_t closest_points(input pair_t p);
    near_t o;
    wide_t a, b, c, d, e, det, n1, n2, w[3], df, g;
    a = 0; b = 0; c = 0; d = 0; e = 0; g = 0;
    for (int k = 0; k < 3; k++) begin
      w[k] = wide_t'(p.p1[k]) - wide_t'(p.p2[k]);
      a += wide_t'(p.d1[k]) * wide_t'(p.d1[k]);
      b += wide_t'(p.d1[k]) * wide_t'(p.d2[k]);
      c += wide_t'(p.d2[k]) * wide_t'(p.d2[k]);
      d += wide_t'(p.d1[k]) * w[k];
      e += wide_t'(p.d2[k]) * w[k];
    end
    det = a * c - b * b;
    n1 = b * e - c * d;
    n2 = a * e - b * d;
    o.par = (det == 0);
    for (int k = 0; k < 3; k++) begin
      if (o.par) begin
        o.q1[k] = p.p1[k];
        o.q2[k] = p.p2[k];
      end else begin
        o.q1[k] = sat_coord(div_round(wide_t'(p.d1[k]) * n1, det) + wide_t'(p.p1[k]));
        o.q2[k] = sat_coord(div_round(wide_t'(p.d2[k]) * n2, det) + wide_t'(p.p2[k]));
      end
      df = wide_t'(o.q2[k]) - wide_t'(o.q1[k]);
      g += df * df;
    end
    g = (g + (wide_t'(1) <<< (FB - 1))) >>> FB;
    o.gap = (g >= (wide_t'(1) <<< 64)) ? 64'hFFFF_FFFF_FFFF_FFFF : g[63:0];
    return o;
  endfunction

  class near_board;
    near_t pending[$];

    function void note_pair(pair_t p);
      pending.push_back(closest_points(p));
    endfunction

    task check_result(near_t got);
      near_t x;
      if (pending.size() == 0) begin
        report("result with no item waiting");
        return;
      end
      x = pending.pop_front();
      for (int k = 0; k < 3; k++) begin
        if (got.q1[k] !== x.q1[k])
          report($sformatf("near_first[%0d] %h exp %h", k, got.q1[k], x.q1[k]));
        if (got.q2[k] !== x.q2[k])
          report($sformatf("near_second[%0d] %h exp %h", k, got.q2[k], x.q2[k]));
      end
      if (got.gap !== x.gap) report($sformatf("gap %h exp %h", got.gap, x.gap));
      if (got.par !== x.par) report($sformatf("parallel %b exp %b", got.par, x.par));
    endtask
  endclass

  logic clk_i = 0, rst_ni = 0, push = 0, pop = 0, full, empty;
  crd_t in_f[12];
  crd_t nf_x, nf_y, nf_z, ns_x, ns_y, ns_z;
  logic [63:0] gap_o;
  logic par_o;
  int send_idle = 0, recv_idle = 0;
  near_board board = new();

  skew_line_closest_points_core i_dut (
    .clk_i, .rst_ni, .push, .full,
    .first_dir_x_i(in_f[0]), .first_dir_y_i(in_f[1]), .first_dir_z_i(in_f[2]),
    .first_base_x_i(in_f[3]), .first_base_y_i(in_f[4]), .first_base_z_i(in_f[5]),
    .second_dir_x_i(in_f[6]), .second_dir_y_i(in_f[7]), .second_dir_z_i(in_f[8]),
    .second_base_x_i(in_f[9]), .second_base_y_i(in_f[10]), .second_base_z_i(in_f[11]),
    .empty, .pop,
    .near_first_x_o(nf_x), .near_first_y_o(nf_y), .near_first_z_o(nf_z),
    .near_second_x_o(ns_x), .near_second_y_o(ns_y), .near_second_z_o(ns_z),
    .gap_squared_o(gap_o), .lines_parallel_o(par_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("[skew_line_closest_points_core] ERROR");
    $finish;
  end

  initial foreach (in_f[i]) in_f[i] = '0;

  // result side: pop at random, check on the accepting edge
  always @(posedge clk_i) begin
    near_t got;
    if (rst_ni && pop && !empty) begin
      got.q1 = '{nf_x, nf_y, nf_z};
      got.q2 = '{ns_x, ns_y, ns_z};
      got.gap = gap_o;
      got.par = par_o;
      board.check_result(got);
    end
  end

  always @(negedge clk_i) pop <= rst_ni && ($urandom_range(99) >= recv_idle);

  task automatic send_pair(input pair_t p);
    while ($urandom_range(99) < send_idle) @(negedge clk_i);
    for (int k = 0; k < 3; k++) begin
      in_f[k] = p.d1[k]; in_f[3+k] = p.p1[k];
      in_f[6+k] = p.d2[k]; in_f[9+k] = p.p2[k];
    end
    push = 1;
    do @(posedge clk_i); while (full);
    board.note_pair(p);
    @(negedge clk_i);
    push = 0;
  endtask

  function automatic crd_t rnd_coord();
    case ($urandom_range(5))
      0: return crd_t'($urandom);
      1: return crd_t'($signed($urandom_range(131072)) - 65536);
      2: return $urandom_range(1) ? COORD_MAX : COORD_MIN;
      default: return crd_t'($signed($urandom_range(1 << 24)) - (1 << 23));
    endcase
  endfunction

  function automatic pair_t rnd_pair();
    pair_t p;
    int s;
    for (int k = 0; k < 3; k++) begin
      p.d1[k] = rnd_coord(); p.p1[k] = rnd_coord();
      p.d2[k] = rnd_coord(); p.p2[k] = rnd_coord();
    end
    // parallel or zero-direction pairs now and then
    case ($urandom_range(9))
      0: begin
        s = $urandom_range(4) - 2;
        for (int k = 0; k < 3; k++) p.d2[k] = p.d1[k] * s;
      end
      1: for (int k = 0; k < 3; k++) p.d1[k] = '0;
      default: ;
    endcase
    return p;
  endfunction

  task automatic send_directed();
    pair_t p;
    crd_t one = crd_t'(1 << FB);
    for (int n = 0; n < 12; n++) begin
      for (int k = 0; k < 3; k++) begin
        p.d1[k] = '0; p.p1[k] = '0; p.d2[k] = '0; p.p2[k] = '0;
      end
      case (n)
        0: ;
        1: begin p.d1[0] = one; p.d2[1] = one; p.p2[2] = one; end
        2: begin p.d1[0] = one; p.d2[0] = -one; p.p2[1] = one; end
        3: foreach (p.d1[k]) begin
             p.d1[k] = COORD_MAX; p.p1[k] = COORD_MAX; p.d2[k] = COORD_MIN; p.p2[k] = COORD_MIN;
           end
        4: begin
             p.d1 = '{COORD_MAX, 0, 0}; p.d2 = '{0, COORD_MIN, 0};
             p.p1 = '{COORD_MIN, COORD_MIN, COORD_MIN}; p.p2 = '{COORD_MAX, COORD_MAX, COORD_MAX};
           end
        5: begin p.d1 = '{1, 0, 0}; p.d2 = '{0, 1, 1}; p.p1 = '{0, 0, COORD_MAX}; end
        6: begin p.d1 = '{3, 0, 0}; p.d2 = '{1, 1, 0}; p.p2 = '{1, 0, 5}; end
        7: begin p.d1 = '{-1, 1, 0}; p.d2 = '{1, 1, 0}; p.p1 = '{-1, -1, -1}; end
        8: begin p.d1 = '{COORD_MAX, 1, 0}; p.d2 = '{1, COORD_MAX, 0}; p.p2[2] = COORD_MIN; end
        9: begin p.d2 = '{one, one, one}; p.p1 = '{COORD_MAX, 0, COORD_MIN}; end
        10: begin p.d1 = '{-1, -1, -1}; p.d2 = '{0, 0, 1}; p.p1 = '{-1, -1, -1}; end
        default: begin p.d1 = '{1, 2, 3}; p.d2 = '{3, 2, 1}; p.p2 = '{-7, 9, COORD_MAX}; end
      endcase
      send_pair(p);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    send_directed();
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 24 : (ph == 1) ? 75 : 0;
      recv_idle = (ph == 0) ? 75 : (ph == 1) ? 24 : 0;
      for (int n = 0; n < 315; n++) begin
        if (n == 150) wait (board.pending.size() == 0);
        send_pair(rnd_pair());
      end
    end
    wait (board.pending.size() == 0);
    repeat (60) @(posedge clk_i);
    if (errors == 0) $display("[skew_line_closest_points_core] OK");
    else $display("[skew_line_closest_points_core] ERROR");
    $finish;
  end
endmodule
